/* hdl/i2c_register_transaction_sequencer_macros.svh */
// assertion macros for the register transaction sequencer
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CRTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define I2CRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* hdl/i2crts_pkg.sv */
`default_nettype none

package i2crts_pkg;

    localparam int MAX_BYTES = 4;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_ACK   = 3'd1,
        ACT_NACK  = 3'd2,
        ACT_RX    = 3'd3,
        ACT_MSTOP = 3'd4
    } act_t;

    typedef enum logic [5:0] {
        PH_DEVICE   = 6'b000001,
        PH_REGISTER = 6'b000010,
        PH_WAIT     = 6'b000100,
        PH_READ     = 6'b001000,
        PH_WRITE    = 6'b010000,
        PH_STOP     = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  device_addr;
        logic [7:0]  reg_addr;
        logic        read_mode;
        logic [31:0] write_word;
        logic [2:0]  byte_count;
        logic [7:0]  received_byte;
    } cmd_t;

    typedef struct packed {
        logic        issue_start;
        logic        issue_stop;
        logic        issue_ack;
        logic        issue_nack;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [31:0] read_word;
        logic        busy_res;
        logic        done_res;
        logic        error;
    } rsp_t;

    // handshake between the sequencing core and the result register
    typedef struct packed {
        logic load;
    } core_ctl_t;

    typedef struct packed {
        logic free;
    } slot_sts_t;

    function automatic logic [7:0] lane_of(input logic [31:0] word, input logic [2:0] idx);
        logic [7:0] b;
        begin
            if (idx[2])
            begin
                b = 8'h00;
            end
            else
            begin
                b = word[{idx[1:0], 3'b000} +: 8];
            end
            return b;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/i2crts_core.sv */
`default_nettype none

module i2crts_core #(
    parameter int MAX_BYTES = i2crts_pkg::MAX_BYTES
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cmd_valid,
    output logic                   cmd_stall,
    input  i2crts_pkg::cmd_t       cmd,
    input  i2crts_pkg::slot_sts_t  slot,
    output i2crts_pkg::core_ctl_t  ctl,
    output i2crts_pkg::rsp_t       res
);
    import i2crts_pkg::*;

    logic        cmd_valid_reg;
    cmd_t        cmd_reg;
    phase_t      phase_reg, phase_next;
    logic        active_reg, active_next;
    logic [6:0]  saved_device_reg, saved_device_next;
    logic [7:0]  saved_register_reg, saved_register_next;
    logic        saved_read_mode_reg, saved_read_mode_next;
    logic [31:0] saved_write_word_reg, saved_write_word_next;
    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] read_accum_reg, read_accum_next;
    logic [2:0]  bl_dec;
    logic [2:0]  cnt;
    logic        err;
    logic        advance;
    logic        accept;

    assign advance   = cmd_valid_reg & slot.free;
    assign cmd_stall = cmd_valid_reg & ~slot.free;
    assign accept    = cmd_valid & ~cmd_stall;
    assign ctl.load  = advance;
    assign bl_dec    = bytes_left_reg - 3'd1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        phase_next            = phase_reg;
        active_next           = active_reg;
        saved_device_next     = saved_device_reg;
        saved_register_next   = saved_register_reg;
        saved_read_mode_next  = saved_read_mode_reg;
        saved_write_word_next = saved_write_word_reg;
        bytes_left_next       = bytes_left_reg;
        read_accum_next       = read_accum_reg;
        res                   = '0;
        err                   = 1'b0;
        cnt                   = cmd_reg.byte_count;
        if (cnt == 3'd0)
        begin
            cnt = 3'd1;
        end
        if (int'(cnt) > MAX_BYTES)
        begin
            cnt = 3'(MAX_BYTES);
        end

        if (cmd_reg.action == ACT_START)
        begin
            if (active_reg)
            begin
                err = 1'b1;
            end
            else
            begin
                saved_device_next     = cmd_reg.device_addr;
                saved_register_next   = cmd_reg.reg_addr;
                saved_read_mode_next  = cmd_reg.read_mode;
                saved_write_word_next = cmd_reg.write_word;
                bytes_left_next       = cnt;
                active_next           = 1'b1;
                phase_next            = PH_DEVICE;
                res.issue_start       = 1'b1;
                res.tx_valid          = 1'b1;
                res.tx_byte           = {cmd_reg.device_addr, 1'b0};
            end
        end
        else if (!active_reg)
        begin
            err = 1'b1;
        end
        else
        begin
            case (cmd_reg.action)
                ACT_ACK:
                begin
                    case (phase_reg)
                        PH_DEVICE:
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = saved_register_reg;
                            phase_next   = PH_REGISTER;
                        end
                        PH_REGISTER:
                        begin
                            if (saved_read_mode_reg)
                            begin
                                phase_next      = PH_WAIT;
                                res.issue_start = 1'b1;
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = {saved_device_reg, 1'b1};
                            end
                            else
                            begin
                                bytes_left_next = bl_dec;
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = lane_of(saved_write_word_reg, bl_dec);
                                phase_next      = PH_WRITE;
                            end
                        end
                        PH_WAIT:
                        begin
                            phase_next = PH_READ;
                        end
                        PH_WRITE:
                        begin
                            if (bytes_left_reg == 3'd0)
                            begin
                                phase_next     = PH_STOP;
                                res.issue_stop = 1'b1;
                            end
                            else
                            begin
                                bytes_left_next = bl_dec;
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = lane_of(saved_write_word_reg, bl_dec);
                            end
                        end
                        default:
                        begin
                            err = 1'b1;
                        end
                    endcase
                end
                ACT_NACK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        res.issue_start = 1'b1;
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = {saved_device_reg, 1'b1};
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                ACT_RX:
                begin
                    if (phase_reg == PH_READ && bytes_left_reg != 3'd0)
                    begin
                        bytes_left_next = bl_dec;
                        if (!bl_dec[2])
                        begin
                            read_accum_next[{bl_dec[1:0], 3'b000} +: 8] = cmd_reg.received_byte;
                        end
                        if (bl_dec != 3'd0)
                        begin
                            res.issue_ack = 1'b1;
                        end
                        else
                        begin
                            res.issue_nack = 1'b1;
                            res.issue_stop = 1'b1;
                            phase_next     = PH_STOP;
                        end
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                ACT_MSTOP:
                begin
                    if (phase_reg == PH_STOP)
                    begin
                        phase_next   = PH_DEVICE;
                        active_next  = 1'b0;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        res.read_word = read_accum_next;
        res.busy_res  = active_next;
        res.error     = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_DEVICE;
            active_reg           <= 1'b0;
            saved_device_reg     <= '0;
            saved_register_reg   <= '0;
            saved_read_mode_reg  <= 1'b0;
            saved_write_word_reg <= '0;
            bytes_left_reg       <= '0;
            read_accum_reg       <= '0;
        end
        else if (advance)
        begin
            phase_reg            <= phase_next;
            active_reg           <= active_next;
            saved_device_reg     <= saved_device_next;
            saved_register_reg   <= saved_register_next;
            saved_read_mode_reg  <= saved_read_mode_next;
            saved_write_word_reg <= saved_write_word_next;
            bytes_left_reg       <= bytes_left_next;
            read_accum_reg       <= read_accum_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/i2crts_out.sv */
`default_nettype none

module i2crts_out (
    input  wire                    clk,
    input  wire                    rst_n,
    input  i2crts_pkg::core_ctl_t  ctl,
    input  i2crts_pkg::rsp_t       res,
    output i2crts_pkg::slot_sts_t  slot,
    output logic                   rsp_valid,
    input  wire                    rsp_stall,
    output i2crts_pkg::rsp_t       rsp
);
    import i2crts_pkg::*;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign slot.free = ~rsp_valid_reg | ~rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (slot.free)
        begin
            rsp_valid_reg <= ctl.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rsp_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* hdl/i2c_register_transaction_sequencer.sv */
// channel  | valid      | stall      | payload
// request  | cmd_valid  | cmd_stall  | cmd (i2crts_pkg::cmd_t)
// result   | rsp_valid  | rsp_stall  | rsp (i2crts_pkg::rsp_t)
//
// one result per request, one request per cycle while the result is not stalled
// the rate is set by the single pass from input register through the sequencing
// logic to the result register
// reset is asynchronous, active low, and leaves the block idle in the address phase
// a stalled result holds the result register and stalls the request side in turn
`default_nettype none

module i2c_register_transaction_sequencer #(
    parameter int MAX_BYTES = i2crts_pkg::MAX_BYTES
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cmd_valid,
    output logic              cmd_stall,
    input  i2crts_pkg::cmd_t  cmd,
    output logic              rsp_valid,
    input  wire               rsp_stall,
    output i2crts_pkg::rsp_t  rsp
);
    import i2crts_pkg::*;

`include "i2c_register_transaction_sequencer_macros.svh"

    core_ctl_t ctl;
    slot_sts_t slot;
    rsp_t      res;

    i2crts_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .slot      (slot),
        .ctl       (ctl),
        .res       (res)
    );

    i2crts_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .res       (res),
        .slot      (slot),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `I2CRTS_ASSERT_NOW(a_no_load_when_held, clk, rst_n, ctl.load, !(rsp_valid && rsp_stall))
    `I2CRTS_ASSERT_NOW(a_done_ends_busy, clk, rst_n, rsp_valid && rsp.done_res, !rsp.busy_res && !rsp.error)
    `I2CRTS_ASSERT_NOW(a_start_sends_addr, clk, rst_n, rsp_valid && rsp.issue_start, rsp.tx_valid && rsp.busy_res)
    `I2CRTS_ASSERT_NEXT(a_load_gives_result, clk, rst_n, ctl.load, rsp_valid)

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import i2crts_pkg::*;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 800;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD = 100;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SPARSE,
        FLOW_TOGGLE,
        FLOW_HEAVY
    } flow_mode_t;

    typedef struct {
        cmd_t req;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // sequencer state as the testbench sees it
    phase_t      bus_phase = PH_DEVICE;
    logic        txn_open = 1'b0;
    logic [6:0]  dev_q = '0;
    logic [7:0]  reg_q = '0;
    logic        rd_q = 1'b0;
    logic [31:0] wdata_q = '0;
    logic [2:0]  remaining = '0;
    logic [31:0] rd_accum = '0;

    rsp_t        due_results[$];
    plan_row_t   plan_q[$];

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned writes_done = 0;
    int unsigned reads_done = 0;
    int unsigned events_flagged = 0;
    int unsigned read_retries = 0;
    int unsigned burst_left = 0;
    bit          random_phase = 1'b0;

    bit          held_once = 1'b0;
    int unsigned hold_left = 0;
    int unsigned window_left = 0;
    flow_mode_t  flow = FLOW_FREE;
    logic        toggle_q = 1'b0;

    i2c_register_transaction_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    task automatic advance_sequencer(input cmd_t c, output rsp_t r);
        logic [2:0] n;
        logic       flag;
        begin
            r = '0;
            flag = 1'b0;
            if (c.action == ACT_START)
            begin
                if (txn_open)
                begin
                    flag = 1'b1;
                end
                else
                begin
                    n = c.byte_count;
                    if (n == 3'd0)
                        n = 3'd1;
                    if (n > MAX_BYTES)
                        n = 3'(MAX_BYTES);
                    dev_q = c.device_addr;
                    reg_q = c.reg_addr;
                    rd_q = c.read_mode;
                    wdata_q = c.write_word;
                    remaining = n;
                    txn_open = 1'b1;
                    bus_phase = PH_DEVICE;
                    r.issue_start = 1'b1;
                    r.tx_valid = 1'b1;
                    r.tx_byte = {c.device_addr, 1'b0};
                end
            end
            else if (!txn_open || c.action > ACT_MSTOP)
            begin
                flag = 1'b1;
            end
            else if (c.action == ACT_ACK)
            begin
                case (bus_phase)
                    PH_DEVICE:
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = reg_q;
                        bus_phase = PH_REGISTER;
                    end
                    PH_REGISTER:
                    begin
                        if (rd_q)
                        begin
                            bus_phase = PH_WAIT;
                            r.issue_start = 1'b1;
                            r.tx_valid = 1'b1;
                            r.tx_byte = {dev_q, 1'b1};
                        end
                        else
                        begin
                            remaining = remaining - 3'd1;
                            r.tx_valid = 1'b1;
                            r.tx_byte = (remaining < 3'd4) ? wdata_q[8 * remaining +: 8] : 8'h00;
                            bus_phase = PH_WRITE;
                        end
                    end
                    PH_WAIT:
                    begin
                        bus_phase = PH_READ;
                    end
                    PH_WRITE:
                    begin
                        if (remaining == 3'd0)
                        begin
                            bus_phase = PH_STOP;
                            r.issue_stop = 1'b1;
                        end
                        else
                        begin
                            remaining = remaining - 3'd1;
                            r.tx_valid = 1'b1;
                            r.tx_byte = (remaining < 3'd4) ? wdata_q[8 * remaining +: 8] : 8'h00;
                        end
                    end
                    default:
                    begin
                        flag = 1'b1;
                    end
                endcase
            end
            else if (c.action == ACT_NACK)
            begin
                if (bus_phase == PH_WAIT)
                begin
                    r.issue_start = 1'b1;
                    r.tx_valid = 1'b1;
                    r.tx_byte = {dev_q, 1'b1};
                    read_retries++;
                end
                else
                begin
                    flag = 1'b1;
                end
            end
            else if (c.action == ACT_RX)
            begin
                if (bus_phase == PH_READ && remaining != 3'd0)
                begin
                    remaining = remaining - 3'd1;
                    if (remaining < 3'd4)
                        rd_accum[8 * remaining +: 8] = c.received_byte;
                    if (remaining != 3'd0)
                    begin
                        r.issue_ack = 1'b1;
                    end
                    else
                    begin
                        r.issue_nack = 1'b1;
                        r.issue_stop = 1'b1;
                        bus_phase = PH_STOP;
                    end
                end
                else
                begin
                    flag = 1'b1;
                end
            end
            else
            begin
                if (bus_phase == PH_STOP)
                begin
                    bus_phase = PH_DEVICE;
                    txn_open = 1'b0;
                    r.done_res = 1'b1;
                    if (rd_q)
                        reads_done++;
                    else
                        writes_done++;
                end
                else
                begin
                    flag = 1'b1;
                end
            end
            r.read_word = rd_accum;
            r.busy_res = txn_open;
            r.error = flag;
            if (flag)
                events_flagged++;
        end
    endtask

    function automatic cmd_t req(input logic [2:0] a, input logic [6:0] dev,
                                 input logic [7:0] rg, input logic rd,
                                 input logic [31:0] w, input logic [2:0] n,
                                 input logic [7:0] b);
        cmd_t c;
        begin
            c.action = a;
            c.device_addr = dev;
            c.reg_addr = rg;
            c.read_mode = rd;
            c.write_word = w;
            c.byte_count = n;
            c.received_byte = b;
            return c;
        end
    endfunction

    task automatic add_row(input cmd_t c, input bit typed, input rsp_t want);
        plan_row_t row;
        begin
            row.req = c;
            row.typed = typed;
            row.want = want;
            plan_q.push_back(row);
        end
    endtask

    task automatic build_plan();
        rsp_t e;
        rsp_t none;
        begin
            none = '0;
            e = '0;
            e.error = 1'b1;
            // every bus event but start, and the lowest and highest unused codes, while idle
            add_row(req(ACT_ACK, 7'h7f, 8'hff, 1'b1, 32'hffffffff, 3'd7, 8'hff), 1'b1, e);
            add_row(req(ACT_NACK, '0, '0, 1'b0, '0, '0, '0), 1'b1, e);
            add_row(req(ACT_RX, '0, '0, 1'b0, '0, '0, 8'hff), 1'b1, e);
            add_row(req(ACT_MSTOP, '0, '0, 1'b0, '0, '0, '0), 1'b1, e);
            add_row(req(ACT_UNUSED_LO, '0, '0, 1'b0, '0, '0, '0), 1'b1, e);
            add_row(req(ACT_UNUSED_HI, '0, '0, 1'b0, '0, '0, '0), 1'b1, e);
            // full width write of four bytes, with a start, a nack and a receive out of place
            e = '0;
            e.issue_start = 1'b1;
            e.tx_valid = 1'b1;
            e.tx_byte = 8'hfe;
            e.busy_res = 1'b1;
            add_row(req(ACT_START, 7'h7f, 8'hff, 1'b0, 32'hffffffff, 3'd4, '0), 1'b1, e);
            e = '0;
            e.error = 1'b1;
            e.busy_res = 1'b1;
            add_row(req(ACT_START, '0, '0, 1'b1, '0, 3'd1, '0), 1'b1, e);
            add_row(req(ACT_NACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_RX, '0, '0, 1'b0, '0, '0, 8'h5a), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_MSTOP, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            // read with zero count taken as one, one retry on nack
            add_row(req(ACT_START, '0, '0, 1'b1, '0, 3'd0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_NACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_ACK, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            add_row(req(ACT_RX, '0, '0, 1'b0, '0, '0, 8'hff), 1'b0, none);
            add_row(req(ACT_MSTOP, '0, '0, 1'b0, '0, '0, '0), 1'b0, none);
            // count above the maximum taken as the maximum
            add_row(req(ACT_START, 7'h2a, 8'h81, 1'b1, '0, 3'd7, '0), 1'b0, none);
        end
    endtask

    task automatic put_request(input cmd_t c, input bit typed, input rsp_t want);
        int unsigned gap;
        rsp_t        r;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                if (gap != 0)
                begin
                    cmd_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            cmd <= c;
            cmd_valid <= 1'b1;
            @(posedge clk);
            while (cmd_stall)
                @(posedge clk);
            advance_sequencer(c, r);
            due_results.push_back(typed ? want : r);
            requests_sent++;
            @(negedge clk);
        end
    endtask

    task automatic pick_request(output cmd_t c);
        begin
            c.device_addr = 7'($urandom);
            c.reg_addr = 8'($urandom);
            c.read_mode = 1'($urandom);
            c.write_word = $urandom;
            c.byte_count = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(1, 4));
            c.received_byte = 8'($urandom);
            if ($urandom_range(0, 99) < 12)
            begin
                c.action = 3'($urandom_range(0, 7));
            end
            else if (!txn_open)
            begin
                c.action = ACT_START;
            end
            else
            begin
                case (bus_phase)
                    PH_WAIT:  c.action = ($urandom_range(0, 2) == 0) ? ACT_NACK : ACT_ACK;
                    PH_READ:  c.action = ACT_RX;
                    PH_STOP:  c.action = ACT_MSTOP;
                    default:  c.action = ACT_ACK;
                endcase
            end
        end
    endtask

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        end
    endtask

    task automatic compare_result(input rsp_t want, input rsp_t got);
        begin
            flag_field("issue_start", want.issue_start, got.issue_start);
            flag_field("issue_stop", want.issue_stop, got.issue_stop);
            flag_field("issue_ack", want.issue_ack, got.issue_ack);
            flag_field("issue_nack", want.issue_nack, got.issue_nack);
            flag_field("tx_valid", want.tx_valid, got.tx_valid);
            flag_field("tx_byte", want.tx_byte, got.tx_byte);
            flag_field("read_word", want.read_word, got.read_word);
            flag_field("busy_res", want.busy_res, got.busy_res);
            flag_field("done_res", want.done_res, got.done_res);
            flag_field("error", want.error, got.error);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %0h", $time, rsp);
                mismatches++;
            end
            else
            begin
                compare_result(due_results.pop_front(), rsp);
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        logic nxt;
        nxt = 1'b0;
        if (hold_left != 0)
        begin
            nxt = 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (random_phase && !held_once)
        begin
            nxt = 1'b1;
            held_once <= 1'b1;
            hold_left <= LONG_HOLD - 1;
        end
        else
        begin
            if (window_left == 0)
            begin
                flow <= flow_mode_t'($urandom_range(0, 3));
                window_left <= $urandom_range(20, 150);
            end
            else
            begin
                window_left <= window_left - 1;
            end
            case (flow)
                FLOW_SPARSE: nxt = ($urandom_range(0, 3) == 0);
                FLOW_TOGGLE: nxt = toggle_q;
                FLOW_HEAVY:  nxt = ($urandom_range(0, 3) != 0);
                default:     nxt = 1'b0;
            endcase
            toggle_q <= ~toggle_q;
        end
        rsp_stall <= nxt;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        cmd_t      c;
        plan_row_t row;
        rsp_t      none;
        none = '0;
        build_plan();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (plan_q.size() != 0)
        begin
            row = plan_q.pop_front();
            put_request(row.req, row.typed, row.want);
        end
        random_phase = 1'b1;
        repeat (RANDOM_REQUESTS)
        begin
            pick_request(c);
            put_request(c, 1'b0, none);
        end
        cmd_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests, %0d results: %0d writes and %0d reads completed,",
                 requests_sent, results_seen, writes_done, reads_done);
        $display("%0d unexpected events flagged, %0d repeated starts after nack, %0d mismatches",
                 events_flagged, read_retries, mismatches);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* i2c_register_transaction_sequencer.f */
+incdir+hdl
hdl/i2crts_pkg.sv
hdl/i2crts_core.sv
hdl/i2crts_out.sv
hdl/i2c_register_transaction_sequencer.sv
tb/sv/testbench.sv
